// ===== rtl/psfp_pkg.sv =====
package psfp_pkg;

	// header bytes and minimum length for a frame that yields results
	localparam logic [7:0]  HDR_FIRST  = 8'h42;
	localparam logic [7:0]  HDR_SECOND = 8'h4D;
	localparam logic [15:0] MIN_LEN    = 16'd28;

	// stored payload: frame positions 4..29, packed two bytes per word
	localparam int STORE_BYTES = 26;
	localparam int STORE_WORDS = STORE_BYTES / 2;
	localparam int ADDR_W      = $clog2(STORE_WORDS);

	// result field indexes with a meaning of their own
	localparam logic [3:0] IDX_VERSION = 4'd12;
	localparam logic [3:0] IDX_ERROR   = 4'd13;

	// payload write and frame push from the parser
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic              hi;
		logic [7:0]        data;
		logic              push;
	} buf_wr_t;

	// word read and frame release from the emitter
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              pop;
	} buf_rd_t;

	// buffer status toward both sides
	typedef struct packed {
		logic        full;
		logic        avail;
		logic [15:0] data;
	} buf_stat_t;

endpackage

// ===== rtl/psfp_front.sv =====
module psfp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [7:0]        rx_byte,
	input  psfp_pkg::buf_stat_t stat,
	output psfp_pkg::buf_wr_t wr
);
	import psfp_pkg::*;

	typedef enum logic [2:0] {
		ST_HUNT = 3'b001,
		ST_HDR  = 3'b010,
		ST_DATA = 3'b100
	} state_t;

	state_t      state_q;
	logic [16:0] pos_q;
	logic [15:0] len_q;
	logic [15:0] sum_q;
	logic [7:0]  chk_hi_q;

	logic        acc;
	logic        in_data;
	logic        past_len;
	logic [16:0] pm4;
	logic [16:0] len_end;
	logic [16:0] len_chk;
	logic        frame_end;
	logic        sum_ok;
	logic [15:0] sum_add;

	// position arithmetic and frame end detection
	always_comb begin
		acc       = byte_valid & ~stat.full;
		in_data   = (state_q == ST_DATA);
		pm4       = pos_q - 17'd4;
		len_end   = {1'b0, len_q} + 17'd3;
		len_chk   = {1'b0, len_q} + 17'd2;
		past_len  = (pos_q >= 17'd4);
		sum_add   = sum_q + {8'd0, rx_byte};
		// zero length ends on the low length byte itself
		frame_end = in_data &&
			((pos_q == 17'd3 && len_q[15:8] == 8'd0 && rx_byte == 8'd0) ||
			 (past_len && pos_q >= len_end));
		sum_ok    = past_len && (len_q >= MIN_LEN) && (pos_q == len_end) &&
			({chk_hi_q, rx_byte} == sum_q);
	end

	// payload write and push toward the buffer
	always_comb begin
		byte_stall = stat.full;
		wr.we      = acc && in_data && past_len &&
			(pm4 < 17'(STORE_BYTES));
		wr.addr    = pm4[ADDR_W:1];
		wr.hi      = ~pm4[0];
		wr.data    = rx_byte;
		wr.push    = acc && frame_end && sum_ok;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_HUNT;
			pos_q    <= '0;
			len_q    <= '0;
			sum_q    <= '0;
			chk_hi_q <= '0;
		end else if (acc) begin
			unique case (state_q)
				ST_HDR: begin
					if (rx_byte == HDR_SECOND) begin
						sum_q   <= sum_add;
						pos_q   <= 17'd2;
						state_q <= ST_DATA;
					end else begin
						pos_q   <= '0;
						state_q <= ST_HUNT;
					end
				end
				ST_DATA: begin
					if (pos_q == 17'd2) begin
						len_q <= {rx_byte, 8'd0};
						sum_q <= sum_add;
					end else if (pos_q == 17'd3) begin
						len_q <= {len_q[15:8], rx_byte};
						sum_q <= sum_add;
					end else if (pos_q < len_chk) begin
						sum_q <= sum_add;
					end else if (pos_q == len_chk) begin
						chk_hi_q <= rx_byte;
					end
					if (frame_end) begin
						pos_q   <= '0;
						state_q <= ST_HUNT;
					end else begin
						pos_q <= pos_q + 17'd1;
					end
				end
				default: begin
					if (rx_byte == HDR_FIRST) begin
						sum_q   <= {8'd0, HDR_FIRST};
						pos_q   <= 17'd1;
						state_q <= ST_HDR;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/psfp_frame_buf.sv =====
module psfp_frame_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  psfp_pkg::buf_wr_t   wr,
	input  psfp_pkg::buf_rd_t   rd,
	output psfp_pkg::buf_stat_t stat
);
	import psfp_pkg::*;

	logic [15:0] mem_q [2][STORE_WORDS];
	logic        wr_bank_q;
	logic        rd_bank_q;
	logic [1:0]  count_q;

	// two frame slots: one being filled, one being drained
	always_comb begin
		stat.full  = (count_q == 2'd2);
		stat.avail = (count_q != 2'd0);
		stat.data  = mem_q[rd_bank_q][rd.addr];
	end

	// payload bytes into the fill bank
	always_ff @(posedge clk) begin
		if (wr.we) begin
			if (wr.hi) begin
				mem_q[wr_bank_q][wr.addr][15:8] <= wr.data;
			end else begin
				mem_q[wr_bank_q][wr.addr][7:0] <= wr.data;
			end
		end
	end

	// slot pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_bank_q <= 1'b0;
			rd_bank_q <= 1'b0;
			count_q   <= '0;
		end else begin
			if (wr.push) begin
				wr_bank_q <= ~wr_bank_q;
			end
			if (rd.pop) begin
				rd_bank_q <= ~rd_bank_q;
			end
			case ({wr.push, rd.pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/psfp_back.sv =====
module psfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  psfp_pkg::buf_stat_t stat,
	output psfp_pkg::buf_rd_t   rd,
	output logic                field_valid,
	input  logic                field_stall,
	output logic [3:0]          field_index,
	output logic [15:0]         field_value,
	output logic                last
);
	import psfp_pkg::*;

	logic [3:0]  k_q;
	logic        vld_q;
	logic [3:0]  idx_q;
	logic [15:0] val_q;
	logic        last_q;
	logic        load;
	logic [15:0] val_next;

	// word select and value shaping for the current field
	always_comb begin
		load    = stat.avail && (!vld_q || !field_stall);
		rd.addr = (k_q < IDX_VERSION) ? k_q[ADDR_W-1:0] : IDX_VERSION[ADDR_W-1:0];
		rd.pop  = load && (k_q == IDX_ERROR);
		if (k_q == IDX_VERSION) begin
			val_next = {8'd0, stat.data[15:8]};
		end else if (k_q == IDX_ERROR) begin
			val_next = {8'd0, stat.data[7:0]};
		end else begin
			val_next = stat.data;
		end
	end

	// output register and field counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			vld_q  <= 1'b0;
			idx_q  <= '0;
			val_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			vld_q  <= 1'b1;
			idx_q  <= k_q;
			val_q  <= val_next;
			last_q <= (k_q == IDX_ERROR);
			k_q    <= (k_q == IDX_ERROR) ? 4'd0 : k_q + 4'd1;
		end else if (!field_stall) begin
			vld_q <= 1'b0;
		end
	end

	assign field_valid = vld_q;
	assign field_index = idx_q;
	assign field_value = val_q;
	assign last        = last_q;

endmodule

// ===== rtl/particle_sensor_frame_parser_top.sv =====
// Particle sensor frame parser.
// Byte channel: rx_byte with byte_valid / byte_stall; a request is taken at a
// clock edge with byte_valid high and byte_stall low; one byte per unstalled cycle.
// Field channel: field_index, field_value, last with field_valid / field_stall.
// A frame with a good sum and length of at least 28 gives 14 requests:
// twelve big-endian words, the version byte, then the error code with last set.
// Bad or short frames give nothing.
// The first field is registered from the filled slot after the final checksum
// byte is taken; the rest follow one per cycle while field_stall is low.
// Two frame slots sit between the parser and the emitter, so the parser keeps
// taking bytes while a frame drains. byte_stall rises only when both slots hold
// finished frames not yet emitted, and falls once the emitter releases one.
// A stalled field request holds its value until taken.
// Reset (arst_n low) returns the parser to header hunting and empties both
// slots; no clearing pass is needed.
module particle_sensor_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  rx_byte,
	output logic        field_valid,
	input  logic        field_stall,
	output logic [3:0]  field_index,
	output logic [15:0] field_value,
	output logic        last
);
	import psfp_pkg::*;

	buf_wr_t   wr;
	buf_rd_t   rd;
	buf_stat_t stat;

	// header hunt, length, sum check, payload capture
	psfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.rx_byte    (rx_byte),
		.stat       (stat),
		.wr         (wr)
	);

	// two-slot frame store
	psfp_frame_buf u_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.stat   (stat)
	);

	// field emitter
	psfp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.stat        (stat),
		.rd          (rd),
		.field_valid (field_valid),
		.field_stall (field_stall),
		.field_index (field_index),
		.field_value (field_value),
		.last        (last)
	);

endmodule
